/* src/tsp_pkg.sv */
`default_nettype none
package tsp_pkg;
  localparam int MaxCities = 8;
  localparam int CityBits = 3;
  localparam int CntBits = 4;
  localparam int DistBits = 16;
  localparam int CostBits = 20;
  localparam int OutCostBits = 19;
  localparam int MemDepth = MaxCities * MaxCities;
  localparam int AddrBits = 6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_SCAN, ST_RD, ST_WAIT, ST_PUSH, ST_CLOSE_RD, ST_CLOSE_WAIT,
    ST_CLOSE, ST_EMIT
  } tsp_state_t;

  typedef struct packed {
    logic init;
    logic scan_step;
    logic pop;
    logic rd_edge;
    logic rd_close;
    logic push;
    logic close;
    logic emit_step;
  } tsp_cmd_t;

  typedef struct packed {
    logic at_leaf;
    logic cand_free;
    logic cand_end;
    logic depth_zero;
    logic emit_last;
  } tsp_stat_t;
endpackage
`default_nettype wire

/* src/tsp_ram.sv */
`default_nettype none
module tsp_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/tsp_ctrl.sv */
`default_nettype none
module tsp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              out_take,
  input  wire tsp_pkg::tsp_stat_t stat,
  output tsp_pkg::tsp_cmd_t      cmd,
  output logic                   busy,
  output logic                   emitting
);
  import tsp_pkg::*;
  tsp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (start) state_next = ST_INIT;
      ST_INIT:       state_next = ST_SCAN;
      ST_SCAN: begin
        if (stat.depth_zero) state_next = ST_EMIT;
        else if (stat.at_leaf) state_next = ST_CLOSE_RD;
        else if (stat.cand_end) state_next = ST_SCAN;
        else if (stat.cand_free) state_next = ST_RD;
      end
      ST_RD:         state_next = ST_WAIT;
      ST_WAIT:       state_next = ST_PUSH;
      ST_PUSH:       state_next = ST_SCAN;
      ST_CLOSE_RD:   state_next = ST_CLOSE_WAIT;
      ST_CLOSE_WAIT: state_next = ST_CLOSE;
      ST_CLOSE:      state_next = ST_SCAN;
      ST_EMIT:       if (out_take && stat.emit_last) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    emitting = (state == ST_EMIT);
    unique case (state)
      ST_INIT:     cmd.init = 1'b1;
      ST_SCAN: begin
        if (!stat.depth_zero && !stat.at_leaf) begin
          if (stat.cand_end) cmd.pop = 1'b1;
          else if (!stat.cand_free) cmd.scan_step = 1'b1;
        end
      end
      ST_RD:       cmd.rd_edge = 1'b1;
      ST_PUSH:     cmd.push = 1'b1;
      // keep the closing edge address on the ram until its data is used
      ST_CLOSE_RD, ST_CLOSE_WAIT: cmd.rd_close = 1'b1;
      ST_CLOSE:    cmd.close = 1'b1;
      ST_EMIT:     cmd.emit_step = out_take;
      default:     ;
    endcase
  end
endmodule
`default_nettype wire

/* src/tsp_dp.sv */
`default_nettype none
module tsp_dp (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic [tsp_pkg::CityBits-1:0] ld_from,
  input  wire logic [tsp_pkg::CityBits-1:0] ld_to,
  input  wire logic [tsp_pkg::DistBits-1:0] ld_dist,
  input  wire logic [tsp_pkg::CntBits-1:0]  n_cities,
  input  wire tsp_pkg::tsp_cmd_t            cmd,
  output tsp_pkg::tsp_stat_t                stat,
  output logic [tsp_pkg::CityBits-1:0]      out_pos,
  output logic [tsp_pkg::CityBits-1:0]      out_city,
  output logic [tsp_pkg::OutCostBits-1:0]   out_cost
);
  import tsp_pkg::*;
  logic [CityBits-1:0] path [MaxCities];
  logic [CntBits-1:0]  nxt [MaxCities];
  logic [CostBits-1:0] lcost [MaxCities];
  logic [MaxCities-1:0] visited;
  logic [CityBits-1:0] best [MaxCities];
  logic [CostBits-1:0] best_cost;
  logic                best_valid;
  logic [CntBits-1:0]  depth;
  logic [CityBits-1:0] epos;
  logic [AddrBits-1:0] raddr;
  logic [DistBits-1:0] rdata;
  logic                diag;
  logic [CityBits-1:0] dm1, cand, prev;
  logic [CostBits-1:0] ed, total;

  tsp_ram #(.Width(DistBits), .Depth(MemDepth)) u_mat (
    .clk, .we(load), .waddr({ld_from, ld_to}), .wdata(ld_dist),
    .raddr, .rdata
  );

  assign dm1 = depth[CityBits-1:0] - 1'b1;
  assign cand = nxt[depth[CityBits-1:0]][CityBits-1:0];
  assign prev = path[dm1];
  assign ed = diag ? '0 : CostBits'(rdata);
  assign total = lcost[dm1] + ed;

  always_comb begin
    raddr = {prev, cand};
    if (cmd.rd_close) raddr = {prev, CityBits'(0)};
  end

  always_comb begin
    stat.depth_zero = (depth == '0);
    stat.at_leaf = (depth == n_cities);
    stat.cand_end = (nxt[depth[CityBits-1:0]] >= n_cities);
    stat.cand_free = !visited[cand];
    stat.emit_last = (CntBits'(epos) + 1'b1 == n_cities);
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_edge) diag <= (prev == cand);
    if (cmd.rd_close) diag <= (prev == '0);
    if (cmd.init) begin
      for (int i = 0; i < MaxCities; i++) begin
        path[i] <= '0;
        nxt[i] <= (i == 1) ? CntBits'(1) : '0;
        lcost[i] <= '0;
        best[i] <= '0;
      end
      visited <= MaxCities'(1);
      best_cost <= '1;
      best_valid <= 1'b0;
      depth <= CntBits'(1);
      epos <= '0;
    end
    if (cmd.scan_step) nxt[depth[CityBits-1:0]] <= nxt[depth[CityBits-1:0]] + 1'b1;
    if (cmd.pop) begin
      depth <= depth - 1'b1;
      if (depth > CntBits'(1)) visited[path[dm1]] <= 1'b0;
    end
    if (cmd.push) begin
      nxt[depth[CityBits-1:0]] <= nxt[depth[CityBits-1:0]] + 1'b1;
      path[depth[CityBits-1:0]] <= cand;
      visited[cand] <= 1'b1;
      lcost[depth[CityBits-1:0]] <= total;
      depth <= depth + 1'b1;
      if (depth + 1'b1 < n_cities) nxt[depth[CityBits-1:0] + 1'b1] <= CntBits'(1);
    end
    if (cmd.close) begin
      if (!best_valid || total < best_cost) begin
        best_valid <= 1'b1;
        best_cost <= total;
        for (int i = 0; i < MaxCities; i++) best[i] <= path[i];
      end
      depth <= depth - 1'b1;
      visited[prev] <= 1'b0;
    end
    if (cmd.emit_step) epos <= epos + 1'b1;
  end

  assign out_pos = epos;
  assign out_city = best[epos];
  assign out_cost = best_cost[CostBits-1] ? '1 : best_cost[OutCostBits-1:0];
endmodule
`default_nettype wire

/* src/tsp_exhaustive_tour_search.sv */
// exhaustive tsp tour search. s_axis transfers with tuser=0 load one directed
// edge into the 8x8 distance matrix; tuser=1 starts a depth-first
// search over all tours from city 0 in lexicographic order, keeping the first
// strictly cheapest. every extension or closed tour makes one registered
// matrix read; a skipped (already visited) child or a backtrack makes none.
// after the search, one tour city per m_axis transfer, position 0 first, with
// tlast on the final city. no input is taken during a search or output.
`default_nettype none
module tsp_exhaustive_tour_search (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // from_city[2:0], to_city[5:3], distance[21:6]
  input  wire logic        s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // position[2:0], city[5:3], tour_cost[24:6]
  output logic             m_axis_tlast,  // last
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata      // cities_in_use
);
  import tsp_pkg::*;
  logic [CntBits-1:0] cities_in_use;
  logic [CntBits-1:0] n_cities;
  logic               busy, emitting, acc;
  tsp_cmd_t           cmd;
  tsp_stat_t          stat;
  logic [CityBits-1:0] pos, city;
  logic [OutCostBits-1:0] cost;

  always_ff @(posedge clk) begin
    if (rst) begin
      cities_in_use <= CntBits'(8);
    end else if (cfg_we) begin
      cities_in_use <= cfg_wdata;
    end
  end

  // clamp to 2..8
  assign n_cities = (cities_in_use < CntBits'(2)) ? CntBits'(2) :
                    (cities_in_use > CntBits'(MaxCities)) ? CntBits'(MaxCities) : cities_in_use;

  assign s_axis_tready = !busy;
  assign acc = s_axis_tvalid && s_axis_tready;

  tsp_ctrl u_ctrl (
    .clk, .rst, .start(acc && s_axis_tuser), .out_take(m_axis_tready),
    .stat, .cmd, .busy, .emitting
  );

  tsp_dp u_dp (
    .clk, .load(acc && !s_axis_tuser),
    .ld_from(s_axis_tdata[2:0]), .ld_to(s_axis_tdata[5:3]),
    .ld_dist(s_axis_tdata[21:6]), .n_cities, .cmd, .stat,
    .out_pos(pos), .out_city(city), .out_cost(cost)
  );

  assign m_axis_tvalid = emitting;
  assign m_axis_tdata = {7'd0, cost, city, pos};
  assign m_axis_tlast = stat.emit_last;
endmodule
`default_nettype wire

/* src/tsp_checker.sv */
`default_nettype none
module tsp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  ap_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open during output");
  ap_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped");
  ap_first: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !$past(m_axis_tvalid) |-> m_axis_tdata[2:0] == 3'd0 &&
    m_axis_tdata[5:3] == 3'd0) else $error("tour does not start at home");
  ap_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("output past last");
endmodule

bind tsp_exhaustive_tour_search tsp_checker u_chk (.*);
`default_nettype wire
